// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of i_clk, switched off while reset is held.
`define LUHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every rising edge of i_clk, reset included.
`define LUHS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- sv/luhs_pkg.sv -----
`default_nettype none
package luhs_pkg;

    localparam int GAME_CODE_W    = 32;
    localparam int UPLOAD_W       = 21;
    localparam int PORT_W         = 2;
    localparam int WORD_W         = 32;
    localparam int WORD_INDEX_W   = 18;
    // Enough for the word count of the largest length the register can hold.
    localparam int INDEX_W        = UPLOAD_W - 1;
    localparam int PHASE_W        = 4;
    localparam int CMD_W          = 3;
    localparam int OUTCOME_W      = 2;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 32;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 4'd0;
    localparam logic [PHASE_W-1:0] PH_RESET  = 4'd1;
    localparam logic [PHASE_W-1:0] PH_STAT1  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_RDCODE = 4'd3;
    localparam logic [PHASE_W-1:0] PH_STAT2  = 4'd4;
    localparam logic [PHASE_W-1:0] PH_WRCODE = 4'd5;
    localparam logic [PHASE_W-1:0] PH_STAT3  = 4'd6;
    localparam logic [PHASE_W-1:0] PH_WRSIZE = 4'd7;
    localparam logic [PHASE_W-1:0] PH_RDSIZE = 4'd8;
    localparam logic [PHASE_W-1:0] PH_POLL   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_WRDATA = 4'd10;

    localparam logic [CMD_W-1:0] CMD_RESET  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_STATUS = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DONE   = 3'd4;

    localparam logic [OUTCOME_W-1:0] OUT_PENDING = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_SUCCESS = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_FAILURE = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_GAME_CODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPLOAD_BYTES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINK_PORT    = 2'd2;

    localparam logic OP_START    = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    localparam logic [7:0] STATUS_BOOT  = 8'h28;
    localparam logic [7:0] STATUS_CODE  = 8'h20;
    localparam logic [7:0] STATUS_READY = 8'h30;
    localparam logic [7:0] STATUS_BUSY_MASK = 8'h02;
    localparam logic [7:0] STATUS_LIVE_MASK = 8'h30;

    localparam logic [GAME_CODE_W-1:0] GAME_CODE_RESET = 32'h5053_414A;
    localparam logic [PORT_W-1:0]      LINK_PORT_RESET = 2'd1;

    typedef struct packed {
        logic              op;
        logic              link_error;
        logic [7:0]        status_byte;
        logic [WORD_W-1:0] read_word;
        logic [WORD_W-1:0] payload_word;
    } t_in_item;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [PORT_W-1:0]       port;
        logic [WORD_W-1:0]       write_word;
        logic [WORD_INDEX_W-1:0] word_index;
        logic [OUTCOME_W-1:0]    outcome;
        logic                    last;
    } t_out_item;

    // Decision of one step: next state and the result, if any.
    typedef struct packed {
        logic                    emit;
        logic [PHASE_W-1:0]      phase;
        logic [INDEX_W-1:0]      index;
        logic [CMD_W-1:0]        command;
        logic [WORD_W-1:0]       write_word;
        logic [WORD_INDEX_W-1:0] word_index;
        logic [OUTCOME_W-1:0]    outcome;
    } t_step;

    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage
`default_nettype wire

// ----- sv/luhs_step.sv -----
`default_nettype none
module luhs_step #(
    parameter int MAX_BYTES = 1048576
) (
    input  wire logic [luhs_pkg::PHASE_W-1:0]     i_phase,
    input  wire logic [luhs_pkg::INDEX_W-1:0]     i_index,
    input  wire luhs_pkg::t_in_item               i_item,
    input  wire logic [luhs_pkg::GAME_CODE_W-1:0] i_game_code,
    input  wire logic [luhs_pkg::UPLOAD_W-1:0]    i_upload_bytes,
    output luhs_pkg::t_step                       o_step
);

    localparam logic [31:0] MaxBytes = 32'(MAX_BYTES);

    logic [luhs_pkg::WORD_W-1:0]  size_word;
    logic [luhs_pkg::INDEX_W-1:0] index_inc;
    logic [luhs_pkg::INDEX_W+1:0] bytes_done;
    logic                         too_long;

    assign size_word  = luhs_pkg::WORD_W'(i_upload_bytes);
    assign index_inc  = i_index + luhs_pkg::INDEX_W'(1);
    assign bytes_done = {index_inc, 2'b00};
    assign too_long   = 32'(i_upload_bytes) > MaxBytes;

    always_comb begin
        o_step.emit       = 1'b1;
        o_step.phase      = i_phase;
        o_step.index      = i_index;
        o_step.command    = luhs_pkg::CMD_DONE;
        o_step.write_word = '0;
        o_step.word_index = '0;
        o_step.outcome    = luhs_pkg::OUT_FAILURE;

        if (i_item.op == luhs_pkg::OP_START) begin
            o_step.index = '0;
            if (too_long) begin
                o_step.phase = luhs_pkg::PH_IDLE;
            end else begin
                o_step.phase   = luhs_pkg::PH_RESET;
                o_step.command = luhs_pkg::CMD_RESET;
                o_step.outcome = luhs_pkg::OUT_PENDING;
            end
        end else if (i_phase == luhs_pkg::PH_IDLE || i_phase > luhs_pkg::PH_WRDATA) begin
            o_step.emit  = 1'b0;
            o_step.phase = luhs_pkg::PH_IDLE;
        end else if (i_item.link_error) begin
            o_step.phase = luhs_pkg::PH_IDLE;
            o_step.index = '0;
        end else begin
            // Failure is the default; each accepted transition overrides it.
            o_step.phase = luhs_pkg::PH_IDLE;
            o_step.index = '0;
            unique case (i_phase)
                luhs_pkg::PH_RESET: begin
                    o_step.phase   = luhs_pkg::PH_STAT1;
                    o_step.command = luhs_pkg::CMD_STATUS;
                    o_step.outcome = luhs_pkg::OUT_PENDING;
                end
                luhs_pkg::PH_STAT1: begin
                    if (i_item.status_byte == luhs_pkg::STATUS_BOOT) begin
                        o_step.phase   = luhs_pkg::PH_RDCODE;
                        o_step.command = luhs_pkg::CMD_READ;
                        o_step.outcome = luhs_pkg::OUT_PENDING;
                    end
                end
                luhs_pkg::PH_RDCODE: begin
                    if (i_item.read_word == i_game_code) begin
                        o_step.phase   = luhs_pkg::PH_STAT2;
                        o_step.command = luhs_pkg::CMD_STATUS;
                        o_step.outcome = luhs_pkg::OUT_PENDING;
                    end
                end
                luhs_pkg::PH_STAT2: begin
                    if (i_item.status_byte == luhs_pkg::STATUS_CODE) begin
                        o_step.phase      = luhs_pkg::PH_WRCODE;
                        o_step.command    = luhs_pkg::CMD_WRITE;
                        o_step.write_word = i_game_code;
                        o_step.outcome    = luhs_pkg::OUT_PENDING;
                    end
                end
                luhs_pkg::PH_WRCODE: begin
                    o_step.phase   = luhs_pkg::PH_STAT3;
                    o_step.command = luhs_pkg::CMD_STATUS;
                    o_step.outcome = luhs_pkg::OUT_PENDING;
                end
                luhs_pkg::PH_STAT3: begin
                    if (i_item.status_byte == luhs_pkg::STATUS_READY) begin
                        o_step.phase      = luhs_pkg::PH_WRSIZE;
                        o_step.command    = luhs_pkg::CMD_WRITE;
                        o_step.write_word = luhs_pkg::swap_bytes(size_word);
                        o_step.outcome    = luhs_pkg::OUT_PENDING;
                    end
                end
                luhs_pkg::PH_WRSIZE: begin
                    o_step.phase   = luhs_pkg::PH_RDSIZE;
                    o_step.command = luhs_pkg::CMD_READ;
                    o_step.outcome = luhs_pkg::OUT_PENDING;
                end
                luhs_pkg::PH_RDSIZE: begin
                    if (luhs_pkg::swap_bytes(i_item.read_word) == size_word) begin
                        if (i_upload_bytes == '0) begin
                            o_step.outcome = luhs_pkg::OUT_SUCCESS;
                        end else begin
                            o_step.phase   = luhs_pkg::PH_POLL;
                            o_step.command = luhs_pkg::CMD_STATUS;
                            o_step.outcome = luhs_pkg::OUT_PENDING;
                        end
                    end
                end
                luhs_pkg::PH_POLL: begin
                    // A busy receiver is polled again as long as it stays alive.
                    if ((i_item.status_byte & luhs_pkg::STATUS_BUSY_MASK) == '0) begin
                        o_step.phase      = luhs_pkg::PH_WRDATA;
                        o_step.index      = i_index;
                        o_step.command    = luhs_pkg::CMD_WRITE;
                        o_step.write_word = i_item.payload_word;
                        o_step.word_index = i_index[luhs_pkg::WORD_INDEX_W-1:0];
                        o_step.outcome    = luhs_pkg::OUT_PENDING;
                    end else if ((i_item.status_byte & luhs_pkg::STATUS_LIVE_MASK)
                                 == luhs_pkg::STATUS_LIVE_MASK) begin
                        o_step.phase      = luhs_pkg::PH_POLL;
                        o_step.index      = i_index;
                        o_step.command    = luhs_pkg::CMD_STATUS;
                        o_step.word_index = i_index[luhs_pkg::WORD_INDEX_W-1:0];
                        o_step.outcome    = luhs_pkg::OUT_PENDING;
                    end
                end
                luhs_pkg::PH_WRDATA: begin
                    if (bytes_done >= (luhs_pkg::INDEX_W+2)'(i_upload_bytes)) begin
                        o_step.outcome = luhs_pkg::OUT_SUCCESS;
                    end else begin
                        o_step.phase      = luhs_pkg::PH_POLL;
                        o_step.index      = index_inc;
                        o_step.command    = luhs_pkg::CMD_STATUS;
                        o_step.word_index = index_inc[luhs_pkg::WORD_INDEX_W-1:0];
                        o_step.outcome    = luhs_pkg::OUT_PENDING;
                    end
                end
                default: begin
                    o_step.emit = 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/link_upload_handshake_sequencer.sv -----
// Host-side sequencer for a link boot handshake.
// Input channel (i_in_valid / o_in_stall / i_in): a start item begins the
// sequence; each later response item answers the command last issued and
// carries the status byte, read data and the payload word that was asked for.
// Output channel (o_out_valid / i_out_stall / o_out): the next link command,
// or a finished result with last set and the outcome.
// Configuration (i_cfg_we / i_cfg_index / i_cfg_wdata) is to be written by
// the user while idle; the block does not enforce it. An accepted transfer
// is captured in an input register; its step is decided by the state register
// and a compare and lands in the output register once that is free. One item
// is taken every cycle unless the receiver stalls; responses while idle give no result.
// When the receiver stalls, the output register holds, the input register
// fills, and o_in_stall rises only once both are occupied.
// Reset (synchronous, active low) empties both registers, returns the
// sequence to idle and loads the register defaults: code 'PSAJ', zero
// length, link channel 1.
`default_nettype none
module link_upload_handshake_sequencer #(
    parameter int MAX_BYTES = 1048576
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire luhs_pkg::t_in_item                i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output luhs_pkg::t_out_item                    o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [luhs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [luhs_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    logic [luhs_pkg::GAME_CODE_W-1:0] r_game_code;
    logic [luhs_pkg::UPLOAD_W-1:0]    r_upload_bytes;
    logic [luhs_pkg::PORT_W-1:0]      r_link_port;

    logic [luhs_pkg::PHASE_W-1:0]     r_phase;
    logic [luhs_pkg::INDEX_W-1:0]     r_data_index;

    logic                             r_in_valid;
    luhs_pkg::t_in_item               r_in;
    logic                             r_out_valid;
    luhs_pkg::t_out_item              r_out;
    luhs_pkg::t_out_item              n_out;

    luhs_pkg::t_step                  step;
    logic                             advance;
    logic                             in_accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    luhs_step #(
        .MAX_BYTES(MAX_BYTES)
    ) u_step (
        .i_phase        (r_phase),
        .i_index        (r_data_index),
        .i_item         (r_in),
        .i_game_code    (r_game_code),
        .i_upload_bytes (r_upload_bytes),
        .o_step         (step)
    );

    always_comb begin
        n_out.command    = step.command;
        n_out.port       = r_link_port;
        n_out.write_word = step.write_word;
        n_out.word_index = step.word_index;
        n_out.outcome    = step.outcome;
        n_out.last       = (step.command == luhs_pkg::CMD_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_game_code    <= luhs_pkg::GAME_CODE_RESET;
            r_upload_bytes <= '0;
            r_link_port    <= luhs_pkg::LINK_PORT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                luhs_pkg::CFG_GAME_CODE:    r_game_code    <= i_cfg_wdata;
                luhs_pkg::CFG_UPLOAD_BYTES: begin
                    r_upload_bytes <= i_cfg_wdata[luhs_pkg::UPLOAD_W-1:0];
                end
                luhs_pkg::CFG_LINK_PORT:    r_link_port <= i_cfg_wdata[luhs_pkg::PORT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_phase      <= luhs_pkg::PH_IDLE;
            r_data_index <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid  <= step.emit;
                r_phase      <= step.phase;
                r_data_index <= step.index;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`include "assert_macros.svh"

    `LUHS_ASSERT(a_stall_needs_item, !o_in_stall || r_in_valid, "stall without held item")
    `LUHS_ASSERT(a_idle_index_clear, r_phase != luhs_pkg::PH_IDLE || r_data_index == '0, "idle with nonzero word index")
    `LUHS_ASSERT(a_done_has_outcome, !r_out_valid || ((r_out.command == luhs_pkg::CMD_DONE) == (r_out.outcome != luhs_pkg::OUT_PENDING)), "outcome does not match command")
    `LUHS_ASSERT(a_done_goes_idle, (advance && step.emit && step.command == luhs_pkg::CMD_DONE) |=> r_phase == luhs_pkg::PH_IDLE, "finished result left sequence running")

endmodule
`default_nettype wire
